// ===== sv/dsnt_pkg.sv =====
// dsnt_pkg: shared types, sizes and codes for the distance sorted neighbour table
// no dependencies

package dsnt_pkg;

  localparam int PARTICLES = 256;
  localparam int SLOTS     = 16;

  localparam int PART_W  = $clog2(PARTICLES);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ENT_AW  = PART_W + SLOT_W;
  localparam int ENT_DEPTH = 1 << ENT_AW;

  typedef logic [PART_W-1:0] part_idx_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ENT_AW-1:0] ent_addr_t;

  typedef logic [3:0] slot_f_t;
  typedef logic [4:0] cnt_f_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         particle;
    logic [7:0]         neighbour;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [31:0]        sq_dist;
    logic [3:0]         read_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic [4:0]         count;
    logic [7:0]         out_neighbour;
    logic signed [15:0] out_dx;
    logic signed [15:0] out_dy;
    logic signed [15:0] out_dz;
    logic [31:0]        out_sq_dist;
  } rsp_t;

  typedef struct packed {
    logic [7:0]         neighbour;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [31:0]        sq_dist;
  } entry_t;

  typedef struct packed {
    logic      rd_en;
    part_idx_t rd_addr;
    logic      wr_en;
    part_idx_t wr_addr;
    cnt_t      wr_data;
  } cnt_req_t;

endpackage

// ===== sv/dsnt_count_table.sv =====
// dsnt_count_table: per-particle list count memory with a registered read port
// invalid entries read as zero; depends on dsnt_pkg

module dsnt_count_table (
  input  logic                clk,
  input  logic                rst_n,
  input  dsnt_pkg::cnt_req_t  req,
  output dsnt_pkg::cnt_t      rd_cnt
);

  dsnt_pkg::cnt_t              mem [dsnt_pkg::PARTICLES];
  logic [dsnt_pkg::PARTICLES-1:0] valid_r;
  dsnt_pkg::cnt_t              rd_data_r;
  logic                        rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_cnt = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== sv/distance_sorted_neighbour_table_core.sv =====
// distance_sorted_neighbour_table_core: sorted neighbour lists per particle
// S_IDLE accepts, S_CNT reads the count; clear, full insert, unused command, out-of-range
// read go to S_DONE; read via S_RDATA; insert shifts larger entries in S_SCAN, one per
// cycle, then S_PUT; no new request until S_DONE loads out_data, held while out_ready low
// reset: list counts cleared at once by per-particle valid bits, no clearing pass;
// entry memory not cleared; depends on dsnt_pkg and dsnt_count_table

module distance_sorted_neighbour_table_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dsnt_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dsnt_pkg::rsp_t  out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CNT   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  dsnt_pkg::req_t       req_r, req_nxt;
  dsnt_pkg::cnt_t       cnt_r, cnt_nxt;
  dsnt_pkg::slot_idx_t  l_r, l_nxt;
  dsnt_pkg::rsp_t       res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dsnt_pkg::rsp_t       out_data_r, out_data_nxt;

  dsnt_pkg::cnt_req_t   cnt_req;
  dsnt_pkg::cnt_t       rd_cnt;

  dsnt_pkg::entry_t     ent_mem [dsnt_pkg::ENT_DEPTH];
  dsnt_pkg::entry_t     ent_rd_r;
  logic                 ent_re, ent_we;
  dsnt_pkg::ent_addr_t  ent_raddr, ent_waddr;
  dsnt_pkg::entry_t     ent_wdata;

  dsnt_pkg::part_idx_t  p;
  dsnt_pkg::entry_t     new_ent;

  dsnt_count_table u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cnt_req),
    .rd_cnt (rd_cnt)
  );

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_raddr];
    end
  end

  assign p = dsnt_pkg::part_idx_t'(req_r.particle);

  assign new_ent = '{neighbour: req_r.neighbour, dx: req_r.dx, dy: req_r.dy,
                     dz: req_r.dz, sq_dist: req_r.sq_dist};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    cnt_req.rd_en   = 1'b0;
    cnt_req.rd_addr = dsnt_pkg::part_idx_t'(in_data.particle);
    cnt_req.wr_en   = 1'b0;
    cnt_req.wr_addr = p;
    cnt_req.wr_data = '0;

    ent_re    = 1'b0;
    ent_raddr = {p, l_r};
    ent_we    = 1'b0;
    ent_waddr = {p, l_r};
    ent_wdata = new_ent;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_data;
          cnt_req.rd_en = 1'b1;
          state_nxt     = S_CNT;
        end
      end
      S_CNT: begin
        cnt_nxt = rd_cnt;
        res_nxt = '0;
        res_nxt.count = dsnt_pkg::cnt_f_t'(rd_cnt);
        case (req_r.cmd)
          dsnt_pkg::CMD_INSERT: begin
            if (rd_cnt >= dsnt_pkg::cnt_t'(dsnt_pkg::SLOTS)) begin
              res_nxt.status = dsnt_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              l_nxt = dsnt_pkg::slot_idx_t'(rd_cnt);
              if (rd_cnt == '0) begin
                state_nxt = S_PUT;
              end else begin
                ent_re    = 1'b1;
                ent_raddr = {p, dsnt_pkg::slot_idx_t'(rd_cnt - dsnt_pkg::cnt_t'(1))};
                state_nxt = S_SCAN;
              end
            end
          end
          dsnt_pkg::CMD_CLEAR: begin
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_data = '0;
            res_nxt.count   = '0;
            state_nxt       = S_DONE;
          end
          dsnt_pkg::CMD_READ: begin
            res_nxt.slot = req_r.read_slot;
            if (dsnt_pkg::cnt_t'(req_r.read_slot) >= rd_cnt) begin
              res_nxt.status = dsnt_pkg::ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              ent_re    = 1'b1;
              ent_raddr = {p, dsnt_pkg::slot_idx_t'(req_r.read_slot)};
              state_nxt = S_RDATA;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (ent_rd_r.sq_dist > req_r.sq_dist) begin
          ent_we    = 1'b1;
          ent_waddr = {p, l_r};
          ent_wdata = ent_rd_r;
          l_nxt     = l_r - dsnt_pkg::slot_idx_t'(1);
          if (l_r == dsnt_pkg::slot_idx_t'(1)) begin
            state_nxt = S_PUT;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = {p, l_r - dsnt_pkg::slot_idx_t'(2)};
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ent_we          = 1'b1;
        ent_waddr       = {p, l_r};
        ent_wdata       = new_ent;
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_data = cnt_r + dsnt_pkg::cnt_t'(1);
        res_nxt.slot    = dsnt_pkg::slot_f_t'(l_r);
        res_nxt.count   = dsnt_pkg::cnt_f_t'(cnt_r + dsnt_pkg::cnt_t'(1));
        state_nxt       = S_DONE;
      end
      S_RDATA: begin
        res_nxt.out_neighbour = ent_rd_r.neighbour;
        res_nxt.out_dx        = ent_rd_r.dx;
        res_nxt.out_dy        = ent_rd_r.dy;
        res_nxt.out_dz        = ent_rd_r.dz;
        res_nxt.out_sq_dist   = ent_rd_r.sq_dist;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    l_r        <= l_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_we && ent_re) |-> (ent_waddr != ent_raddr))
    else $error("entry read and write hit the same slot");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (dsnt_pkg::cnt_t'(l_r) <= cnt_r && l_r != '0))
    else $error("shift position outside list");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == dsnt_pkg::ST_FULL) |->
    (out_data_r.count == dsnt_pkg::cnt_f_t'(dsnt_pkg::SLOTS)))
    else $error("full status with list not full");

  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_req.wr_en |-> (state_r == S_PUT || state_r == S_CNT))
    else $error("count written outside update states");

endmodule
